### hw/rtl/tmdrop_pkg.sv
// shared types, constants and colour packing for the drop-shadow texel block
package tmdrop_pkg;

  localparam int MAX_ROW_WIDTH = 1024;
  // column index into the line buffer
  localparam int COL_W = $clog2(MAX_ROW_WIDTH);
  // row_width register field width
  localparam int RW_W = 11;
  // width for comparing columns against a saturated row width
  localparam int WID_W = ($clog2(MAX_ROW_WIDTH + 1) > RW_W) ? $clog2(MAX_ROW_WIDTH + 1) : RW_W;

  localparam int ADDR_W = 4;
  localparam logic [1:0] REG_TEXT_COLOR   = 2'd0;
  localparam logic [1:0] REG_SHADOW_COLOR = 2'd1;
  localparam logic [1:0] REG_ROW_WIDTH    = 2'd2;

  // output queue
  localparam int QDEPTH = 8;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [31:0] mask_pixel;
    logic        frame_start;
    logic        pad_row;
  } in_t;

  typedef struct packed {
    logic [15:0] texel;
    logic        right_edge;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic             first_row;
    logic             last_col;
  } col_info_t;

  function automatic logic [15:0] pack4444(input logic [31:0] c);
    return {c[31:28], c[23:20], c[15:12], c[7:4]};
  endfunction

endpackage

### hw/rtl/tmdrop_ram.sv
// generic single-write, single-read ram with registered read data
module tmdrop_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/tmdrop_col.sv
// column and first-row tracking for incoming pixels
module tmdrop_col
  import tmdrop_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic            frame_start,
  input  logic [RW_W-1:0] row_width,
  output col_info_t       info
);

  logic [COL_W-1:0] col_r, col_nxt;
  logic             first_r, first_nxt;
  logic [WID_W-1:0] w;
  logic [WID_W-1:0] col0;
  logic             first0;
  logic [WID_W-1:0] col_plus;

  always_comb begin
    // saturate width into 1..MAX_ROW_WIDTH
    w = WID_W'(row_width);
    if (w == '0) begin
      w = WID_W'(1);
    end else if (w > WID_W'(MAX_ROW_WIDTH)) begin
      w = WID_W'(MAX_ROW_WIDTH);
    end

    col0   = frame_start ? '0 : WID_W'(col_r);
    first0 = frame_start ? 1'b1 : first_r;
    // width lowered mid-row: close the current row first
    if (col0 >= w) begin
      col0   = '0;
      first0 = 1'b0;
    end

    col_plus       = col0 + WID_W'(1);
    info.col       = col0[COL_W-1:0];
    info.first_row = first0;
    info.last_col  = (col_plus == w);

    col_nxt   = col_r;
    first_nxt = first_r;
    if (adv) begin
      if (info.last_col) begin
        col_nxt   = '0;
        first_nxt = 1'b0;
      end else begin
        col_nxt   = col_plus[COL_W-1:0];
        first_nxt = first0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      first_r <= 1'b1;
    end else begin
      col_r   <= col_nxt;
      first_r <= first_nxt;
    end
  end

endmodule

### hw/rtl/tmdrop_outq.sv
// small result queue taking up to two texels per cycle
module tmdrop_outq
  import tmdrop_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        push_n,
  input  out_t              push0,
  input  out_t              push1,
  output logic              out_valid,
  input  logic              out_ready,
  output out_t              out_data,
  output logic [QCNT_W-1:0] count
);

  out_t              q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt;
  logic [QPTR_W-1:0] rd_r, rd_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              pop;
  logic [QPTR_W-1:0] wr_plus;

  assign out_valid = (cnt_r != '0);
  assign out_data  = q_r[rd_r];
  assign pop       = out_valid && out_ready;
  assign wr_plus   = wr_r + QPTR_W'(1);
  assign count     = cnt_r;

  always_comb begin
    wr_nxt  = wr_r + QPTR_W'(push_n);
    rd_nxt  = pop ? rd_r + QPTR_W'(1) : rd_r;
    cnt_nxt = cnt_r + QCNT_W'(push_n) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      q_r[wr_r] <= push0;
    end
    if (push_n == 2'd2) begin
      q_r[wr_plus] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### hw/rtl/text_mask_drop_shadow_argb4444_core.sv
// top level of the drop-shadow text texel generator, argb4444 output
//
// Glyph-mask pixels enter on in_valid/in_ready in raster order, one transfer
// per pixel; texels leave on out_valid/out_ready. Colours and row width are
// written over the APB-style port (text colour at 0x0, shadow colour at 0x4,
// row width at 0x8); the user must write them only while the block is idle,
// which the block itself does not enforce; pready is tied high. Texels are
// formed in the second stage from the registered line-buffer read and leave
// through the result queue. A new pixel is taken every cycle while in_ready
// is high. With a shadow colour set, the last pixel of each row gives a
// second, right-edge texel, so rows of width w produce w+1 texels; the output
// port delivers one per cycle, so the output, not the input, sets the
// sustained rate. The line buffer is a 1024 x 1 synchronous ram, read every
// cycle and written at most once per cycle, with forwarding when a pixel
// reads the entry the previous one is writing. Reset clears column state, the
// queue and registers; the line buffer needs no clearing since reads in a
// frame's first row are ignored and that row writes the entries the next row
// reads. When the receiver stalls, texels collect in an 8-entry queue and
// in_ready drops once the queue could not hold the results in flight.
module text_mask_drop_shadow_argb4444_core
  import tmdrop_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_t               in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_t              out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [31:0]     text_color_r;
  logic [31:0]     shadow_color_r;
  logic [RW_W-1:0] row_width_r;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_color_r   <= '0;
      shadow_color_r <= '0;
      row_width_r    <= RW_W'(1);
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_TEXT_COLOR:   text_color_r   <= pwdata;
        REG_SHADOW_COLOR: shadow_color_r <= pwdata;
        REG_ROW_WIDTH:    row_width_r    <= pwdata[RW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_TEXT_COLOR:   prdata = text_color_r;
      REG_SHADOW_COLOR: prdata = shadow_color_r;
      REG_ROW_WIDTH:    prdata = {{(32-RW_W){1'b0}}, row_width_r};
      default:          prdata = '0;
    endcase
  end

  logic        shadow_on;
  logic [15:0] fg, sh;
  assign shadow_on = (shadow_color_r != '0);
  assign fg        = pack4444(text_color_r);
  assign sh        = pack4444(shadow_color_r);

  // front stage: column tracking and line-buffer read
  logic      in_xfer, drop, adv;
  col_info_t info;

  assign in_xfer = in_valid && in_ready;
  // pad pixels without a shadow leave no trace
  assign drop    = in_data.pad_row && !shadow_on;
  assign adv     = in_xfer && !drop;

  tmdrop_col u_col (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .frame_start (in_data.frame_start),
    .row_width   (row_width_r),
    .info        (info)
  );

  // second stage registers
  logic             s1_valid_r;
  logic [COL_W-1:0] s1_col_r;
  logic             s1_first_r, s1_last_r, s1_pad_r, s1_cov_r;
  logic             fwd_hit_r, fwd_data_r;
  logic             prev_up_r;
  logic             ram_rd;

  tmdrop_ram #(
    .WIDTH (1),
    .DEPTH (MAX_ROW_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_col_r),
    .wdata (s1_cov_r),
    .raddr (info.col),
    .rdata (ram_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= adv;
    end
  end

  always_ff @(posedge clk) begin
    s1_col_r   <= info.col;
    s1_first_r <= info.first_row;
    s1_last_r  <= info.last_col;
    s1_pad_r   <= in_data.pad_row;
    s1_cov_r   <= (in_data.mask_pixel != '0) && !in_data.pad_row;
    // the ram returns the old value when read and write meet on one entry
    fwd_hit_r  <= s1_valid_r && (s1_col_r == info.col);
    fwd_data_r <= s1_cov_r;
  end

  logic up, upleft;
  assign up     = fwd_hit_r ? fwd_data_r : ram_rd;
  // a nonzero column always follows its left neighbour directly
  assign upleft = (s1_col_r != '0) && prev_up_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_up_r <= 1'b0;
    end else if (s1_valid_r) begin
      prev_up_r <= up;
    end
  end

  out_t       r0, r1;
  logic       two;
  logic [1:0] push_n;

  always_comb begin
    r0.texel      = '0;
    r0.right_edge = 1'b0;
    two           = shadow_on && s1_last_r;
    r0.last       = !two;
    priority if (!shadow_on) begin
      r0.texel = s1_cov_r ? fg : '0;
    end else if (s1_cov_r) begin
      r0.texel = fg;
    end else if (s1_first_r) begin
      r0.texel = '0;
    end else if (s1_col_r == '0) begin
      r0.texel = (s1_pad_r && up) ? sh : '0;
    end else begin
      r0.texel = (up || upleft) ? sh : '0;
    end
    r1.texel      = (!s1_first_r && up) ? sh : '0;
    r1.right_edge = 1'b1;
    r1.last       = 1'b1;
    push_n        = !s1_valid_r ? 2'd0 : (two ? 2'd2 : 2'd1);
  end

  logic [QCNT_W-1:0] q_count;

  tmdrop_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (push_n),
    .push0     (r0),
    .push1     (r1),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .count     (q_count)
  );

  // room for the item in the second stage and a new one, two texels each
  logic [QCNT_W:0] need;
  assign need     = {1'b0, q_count} + (s1_valid_r ? (QCNT_W+1)'(2) : '0) + (QCNT_W+1)'(2);
  assign in_ready = (need <= (QCNT_W+1)'(QDEPTH));

  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= QCNT_W'(QDEPTH))
    else $error("result queue overflow");

  a_adv_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !(in_data.pad_row && shadow_color_r == '0)) |=> s1_valid_r)
    else $error("accepted pixel missing from second stage");

  a_q_growth: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |=> (q_count != '0))
    else $error("texel not queued");

endmodule
